// ===== rtl/assert_macros.svh =====
// Assertion macros for the top-level decoder, which checks its own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every aclk edge outside reset.
`define DMX_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Checked on every aclk edge, reset included.
`define DMX_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// ===== rtl/dmx_pkg.sv =====
// Types and constants shared by the DMX fixture channel decoder.
package dmx_pkg;

    localparam int CFG_W   = 10;
    localparam int BYTE_W  = 8;
    localparam int VALUE_W = 10;
    localparam int ID_W    = 3;

    typedef enum logic [ID_W-1:0] {
        CH_PAN,
        CH_TILT,
        CH_RED,
        CH_GREEN,
        CH_BLUE,
        CH_STROBE
    } chan_id_t;

    // Position of a byte inside the fixture footprint, counted from 1.
    localparam logic [2:0] FP_PAN    = 3'd1;
    localparam logic [2:0] FP_TILT   = 3'd2;
    localparam logic [2:0] FP_RED    = 3'd3;
    localparam logic [2:0] FP_GREEN  = 3'd4;
    localparam logic [2:0] FP_BLUE   = 3'd5;
    localparam logic [2:0] FP_STROBE = 3'd6;
    localparam logic [2:0] FP_LAST   = 3'd7;

    localparam logic [CFG_W-1:0] START_ADDRESS_RESET = 10'd1;

    // Pan is floor(v * 10000 / 26667), done as v * ceil(2^37 / 26667) * 10000 >> 37.
    localparam int unsigned     PAN_NUM    = 10000;
    localparam int unsigned     PAN_DEN    = 26667;
    localparam int              PAN_SHIFT  = 37;
    localparam longint unsigned PAN_RECIP  =
        ((64'd1 << PAN_SHIFT) + 64'(PAN_DEN) - 64'd1) / 64'(PAN_DEN);
    localparam int              PAN_MULT_W = 36;
    localparam logic [PAN_MULT_W-1:0] PAN_MULT = PAN_MULT_W'(PAN_RECIP * 64'(PAN_NUM));
    localparam int              PAN_PROD_W = BYTE_W + PAN_MULT_W;
    localparam int              PAN_W      = 7;
    localparam logic [VALUE_W-1:0] PAN_MAX = 10'd95;

    typedef struct packed {
        logic [BYTE_W-1:0] rx_byte;
        logic              framing_error;
    } in_word_t;

    typedef struct packed {
        logic [ID_W-1:0]    channel_id;
        logic [VALUE_W-1:0] channel_value;
    } out_word_t;

    // What the slot tracker decided for the accepted word.
    typedef struct packed {
        logic     hit;
        chan_id_t id;
    } decode_t;

endpackage

// ===== rtl/dmx_fixture_channel_decoder.sv =====
// Top level of the DMX fixture channel decoder.
// Each accepted word is one received DMX byte with its framing-error flag;
// a framing error marks a break and starts a new frame. Bytes are counted as
// slots from the start code (slot 0) up to the start address written on the
// cfg port, and the seven bytes from there on are the fixture footprint:
// pan, tilt, red, green, blue, strobe, and one that ends the frame. A word
// yields at most one channel update, and colour updates appear only when the
// colour byte changed. While s_ready is high a word is taken every cycle and
// decoded in one pass through the slot tracker and the scaler into the output
// register; s_ready stays high while that register is empty or being read.
module dmx_fixture_channel_decoder #(
    parameter int MAX_SLOT = 512
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  dmx_pkg::in_word_t         s_data,
    output logic                      m_valid,
    input  logic                      m_ready,
    output dmx_pkg::out_word_t        m_data,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [dmx_pkg::CFG_W-1:0] cfg_data
);

`include "assert_macros.svh"

    logic                        accept;
    logic [dmx_pkg::CFG_W-1:0]   start_address_reg;
    dmx_pkg::decode_t            decode;
    logic [dmx_pkg::VALUE_W-1:0] value;
    logic                        m_valid_reg, m_valid_next;
    dmx_pkg::out_word_t          m_data_reg, m_data_next;

    assign cfg_ready = 1'b1;
    assign s_ready   = !m_valid_reg || m_ready;
    assign accept    = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_address_reg <= dmx_pkg::START_ADDRESS_RESET;
        end else if (cfg_valid) begin
            start_address_reg <= cfg_data;
        end
    end

    dmx_slot_tracker #(
        .MAX_SLOT (MAX_SLOT)
    ) u_tracker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .accept        (accept),
        .in_word       (s_data),
        .start_address (start_address_reg),
        .decode        (decode)
    );

    dmx_chan_scaler u_scaler (
        .rx_byte       (s_data.rx_byte),
        .id            (decode.id),
        .channel_value (value)
    );

    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (accept) begin
            m_valid_next              = decode.hit;
            m_data_next.channel_id    = decode.id;
            m_data_next.channel_value = value;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    `DMX_ASSERT_RST(a_reset_empty, !aresetn |=> !m_valid, "output word valid after reset")
    `DMX_ASSERT(a_break_silent, s_valid && s_ready && s_data.framing_error |=> !m_valid, "break word produced output")
    `DMX_ASSERT(a_pan_range, m_valid && m_data.channel_id == dmx_pkg::CH_PAN |-> m_data.channel_value <= dmx_pkg::PAN_MAX, "pan value out of range")
    `DMX_ASSERT(a_id_range, m_valid |-> m_data.channel_id <= dmx_pkg::CH_STROBE, "channel id out of range")

endmodule

// ===== rtl/dmx_slot_tracker.sv =====
// Frame, slot and footprint tracking with the last colour values.
module dmx_slot_tracker #(
    parameter int MAX_SLOT = 512
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     accept,
    input  dmx_pkg::in_word_t        in_word,
    input  logic [dmx_pkg::CFG_W-1:0] start_address,
    output dmx_pkg::decode_t         decode
);

    localparam int SLOT_W = $clog2(MAX_SLOT + 2);
    localparam logic [SLOT_W-1:0] SLOT_SAT = SLOT_W'(MAX_SLOT + 1);

    logic                       armed_reg, armed_next;
    logic [SLOT_W-1:0]          slot_reg, slot_next;
    logic [2:0]                 idx_reg, idx_next;
    logic [2:0]                 idx_adv;
    logic [dmx_pkg::BYTE_W-1:0] red_reg, red_next;
    logic [dmx_pkg::BYTE_W-1:0] green_reg, green_next;
    logic [dmx_pkg::BYTE_W-1:0] blue_reg, blue_next;
    logic [dmx_pkg::BYTE_W-1:0] v;

    assign v       = in_word.rx_byte;
    assign idx_adv = (idx_reg == dmx_pkg::FP_LAST) ? idx_reg : idx_reg + 3'd1;

    always_comb begin
        armed_next = armed_reg;
        slot_next  = slot_reg;
        idx_next   = idx_reg;
        red_next   = red_reg;
        green_next = green_reg;
        blue_next  = blue_reg;
        decode.hit = 1'b0;
        decode.id  = dmx_pkg::CH_PAN;
        if (in_word.framing_error) begin
            armed_next = 1'b1;
            slot_next  = '0;
            idx_next   = '0;
        end else if (armed_reg) begin
            if (dmx_pkg::CFG_W'(slot_reg) != start_address) begin
                if (slot_reg < SLOT_SAT) begin
                    slot_next = slot_reg + SLOT_W'(1);
                end
            end else begin
                idx_next = idx_adv;
                case (idx_adv)
                    dmx_pkg::FP_PAN: begin
                        decode.hit = 1'b1;
                        decode.id  = dmx_pkg::CH_PAN;
                    end
                    dmx_pkg::FP_TILT: begin
                        decode.hit = 1'b1;
                        decode.id  = dmx_pkg::CH_TILT;
                    end
                    dmx_pkg::FP_RED: begin
                        decode.id = dmx_pkg::CH_RED;
                        if (v != red_reg) begin
                            decode.hit = 1'b1;
                            red_next   = v;
                        end
                    end
                    dmx_pkg::FP_GREEN: begin
                        decode.id = dmx_pkg::CH_GREEN;
                        if (v != green_reg) begin
                            decode.hit = 1'b1;
                            green_next = v;
                        end
                    end
                    dmx_pkg::FP_BLUE: begin
                        decode.id = dmx_pkg::CH_BLUE;
                        if (v != blue_reg) begin
                            decode.hit = 1'b1;
                            blue_next  = v;
                        end
                    end
                    dmx_pkg::FP_STROBE: begin
                        decode.hit = 1'b1;
                        decode.id  = dmx_pkg::CH_STROBE;
                    end
                    default: begin
                        // end of footprint: drop the rest of the frame
                        armed_next = 1'b0;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            armed_reg <= 1'b0;
            slot_reg  <= '0;
            idx_reg   <= '0;
            red_reg   <= '0;
            green_reg <= '0;
            blue_reg  <= '0;
        end else if (accept) begin
            armed_reg <= armed_next;
            slot_reg  <= slot_next;
            idx_reg   <= idx_next;
            red_reg   <= red_next;
            green_reg <= green_next;
            blue_reg  <= blue_next;
        end
    end

endmodule

// ===== rtl/dmx_chan_scaler.sv =====
// Channel value scaling: pan, tilt, inverted PWM and raw strobe.
module dmx_chan_scaler (
    input  logic [dmx_pkg::BYTE_W-1:0]  rx_byte,
    input  dmx_pkg::chan_id_t           id,
    output logic [dmx_pkg::VALUE_W-1:0] channel_value
);

    logic [dmx_pkg::PAN_PROD_W-1:0] pan_prod;
    logic [dmx_pkg::PAN_W-1:0]      pan;
    logic [dmx_pkg::VALUE_W:0]      tilt_x2;

    assign pan_prod = dmx_pkg::PAN_PROD_W'(rx_byte) * dmx_pkg::PAN_PROD_W'(dmx_pkg::PAN_MULT);
    assign pan      = pan_prod[dmx_pkg::PAN_SHIFT +: dmx_pkg::PAN_W];
    // v * 5 as v + 4v, then halve
    assign tilt_x2  = {3'b000, rx_byte} + {1'b0, rx_byte, 2'b00};

    always_comb begin
        case (id)
            dmx_pkg::CH_PAN:    channel_value = dmx_pkg::VALUE_W'(pan);
            dmx_pkg::CH_TILT:   channel_value = tilt_x2[dmx_pkg::VALUE_W:1];
            dmx_pkg::CH_RED,
            dmx_pkg::CH_GREEN,
            dmx_pkg::CH_BLUE:   channel_value = {2'b00, ~rx_byte};
            dmx_pkg::CH_STROBE: channel_value = {2'b00, rx_byte};
            default:            channel_value = '0;
        endcase
    end

endmodule

// ===== tb/dmx_fixture_channel_decoder_tb.sv =====
// Self-checking testbench for the DMX fixture channel decoder.
module dmx_fixture_channel_decoder_tb;

    localparam int MAX_SLOT = 512;
    localparam int N_DIRECTED = 26;
    localparam int N_PHASES = 9;

    typedef struct packed {
        dmx_pkg::in_word_t           word;
        logic                        typed;     // expectation typed into the row
        logic                        typed_hit;
        dmx_pkg::chan_id_t           typed_id;
        logic [dmx_pkg::VALUE_W-1:0] typed_val;
    } byte_row_t;

    logic                      aclk = 1'b0;
    logic                      aresetn = 1'b0;
    logic                      s_valid = 1'b0;
    logic                      s_ready;
    dmx_pkg::in_word_t         s_data = '0;
    logic                      m_valid;
    logic                      m_ready = 1'b0;
    dmx_pkg::out_word_t        m_data;
    logic                      cfg_valid = 1'b0;
    logic                      cfg_ready;
    logic [dmx_pkg::CFG_W-1:0] cfg_data = '0;

    // decoder state as predicted
    bit                        armed = 1'b0;
    logic [9:0]                slot_cnt = '0;
    logic [2:0]                fp_pos = '0;
    logic [7:0]                last_red = '0;
    logic [7:0]                last_green = '0;
    logic [7:0]                last_blue = '0;
    logic [dmx_pkg::CFG_W-1:0] start_addr = dmx_pkg::START_ADDRESS_RESET;

    byte_row_t                 byte_q[$];
    dmx_pkg::out_word_t        update_q[$];
    byte_row_t                 cur_row = '0;
    int                        send_idle = 0;
    int                        recv_idle = 0;
    int                        fail_cnt = 0;
    int                        queued = 0;

    // Directed words; rows with typed = 0 are checked against the predictor.
    byte_row_t directed_rows [N_DIRECTED] = '{
        '{'{8'h5A, 1'b0}, 1'b1, 1'b0, dmx_pkg::CH_PAN,    10'd0},   // ignored before any break
        '{'{8'hFF, 1'b1}, 1'b1, 1'b0, dmx_pkg::CH_PAN,    10'd0},   // break
        '{'{8'h00, 1'b0}, 1'b1, 1'b0, dmx_pkg::CH_PAN,    10'd0},   // start code
        '{'{8'hFF, 1'b0}, 1'b1, 1'b1, dmx_pkg::CH_PAN,    10'd95},
        '{'{8'hFF, 1'b0}, 1'b1, 1'b1, dmx_pkg::CH_TILT,   10'd637},
        '{'{8'h00, 1'b0}, 1'b1, 1'b0, dmx_pkg::CH_PAN,    10'd0},   // red equals reset value
        '{'{8'hFF, 1'b0}, 1'b1, 1'b1, dmx_pkg::CH_GREEN,  10'd0},
        '{'{8'h80, 1'b0}, 1'b0, 1'b0, dmx_pkg::CH_PAN,    10'd0},
        '{'{8'hFF, 1'b0}, 1'b1, 1'b1, dmx_pkg::CH_STROBE, 10'd255},
        '{'{8'hAA, 1'b0}, 1'b1, 1'b0, dmx_pkg::CH_PAN,    10'd0},   // last byte, frame ends
        '{'{8'h55, 1'b0}, 1'b1, 1'b0, dmx_pkg::CH_PAN,    10'd0},   // outside frame
        '{'{8'h00, 1'b1}, 1'b1, 1'b0, dmx_pkg::CH_PAN,    10'd0},
        '{'{8'h00, 1'b0}, 1'b1, 1'b0, dmx_pkg::CH_PAN,    10'd0},
        '{'{8'h00, 1'b0}, 1'b1, 1'b1, dmx_pkg::CH_PAN,    10'd0},
        '{'{8'h00, 1'b0}, 1'b1, 1'b1, dmx_pkg::CH_TILT,   10'd0},
        '{'{8'hFF, 1'b0}, 1'b1, 1'b1, dmx_pkg::CH_RED,    10'd0},
        '{'{8'hFF, 1'b0}, 1'b1, 1'b0, dmx_pkg::CH_PAN,    10'd0},   // green unchanged
        '{'{8'h80, 1'b0}, 1'b1, 1'b0, dmx_pkg::CH_PAN,    10'd0},   // blue unchanged
        '{'{8'h00, 1'b0}, 1'b1, 1'b1, dmx_pkg::CH_STROBE, 10'd0},
        '{'{8'h00, 1'b1}, 1'b1, 1'b0, dmx_pkg::CH_PAN,    10'd0},
        '{'{8'h11, 1'b0}, 1'b1, 1'b0, dmx_pkg::CH_PAN,    10'd0},
        '{'{8'h64, 1'b0}, 1'b0, 1'b0, dmx_pkg::CH_PAN,    10'd0},
        '{'{8'h33, 1'b1}, 1'b1, 1'b0, dmx_pkg::CH_PAN,    10'd0},   // break inside footprint
        '{'{8'h00, 1'b0}, 1'b1, 1'b0, dmx_pkg::CH_PAN,    10'd0},
        '{'{8'h2B, 1'b0}, 1'b0, 1'b0, dmx_pkg::CH_PAN,    10'd0},
        '{'{8'h0F, 1'b0}, 1'b0, 1'b0, dmx_pkg::CH_PAN,    10'd0}
    };

    int phase_addr [N_PHASES]   = '{0, 512, 1, 513, 0, 1023, 2, 3, 0};
    int phase_budget [N_PHASES] = '{40, 1, 40, 1, 40, 1, 40, 40, 40};

    dmx_fixture_channel_decoder #(
        .MAX_SLOT(MAX_SLOT)
    ) dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_data(s_data),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_data(m_data),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data(cfg_data)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    function automatic void decode_byte(input dmx_pkg::in_word_t w, output bit got,
                                        output dmx_pkg::out_word_t upd);
        int unsigned v;
        v = 32'(w.rx_byte);
        got = 1'b0;
        upd = '0;
        if (w.framing_error) begin
            armed = 1'b1;
            slot_cnt = '0;
            fp_pos = '0;
            return;
        end
        if (!armed)
            return;
        if (slot_cnt != start_addr) begin
            if (slot_cnt < MAX_SLOT + 1)
                slot_cnt = slot_cnt + 1'b1;
            return;
        end
        if (fp_pos < dmx_pkg::FP_LAST)
            fp_pos = fp_pos + 1'b1;
        case (fp_pos)
            dmx_pkg::FP_PAN: begin
                got = 1'b1;
                upd = '{dmx_pkg::CH_PAN,
                        dmx_pkg::VALUE_W'(v * dmx_pkg::PAN_NUM / dmx_pkg::PAN_DEN)};
            end
            dmx_pkg::FP_TILT: begin
                got = 1'b1;
                upd = '{dmx_pkg::CH_TILT, dmx_pkg::VALUE_W'((v * 5) >> 1)};
            end
            dmx_pkg::FP_RED: if (v != last_red) begin
                last_red = 8'(v);
                got = 1'b1;
                upd = '{dmx_pkg::CH_RED, dmx_pkg::VALUE_W'(255 - v)};
            end
            dmx_pkg::FP_GREEN: if (v != last_green) begin
                last_green = 8'(v);
                got = 1'b1;
                upd = '{dmx_pkg::CH_GREEN, dmx_pkg::VALUE_W'(255 - v)};
            end
            dmx_pkg::FP_BLUE: if (v != last_blue) begin
                last_blue = 8'(v);
                got = 1'b1;
                upd = '{dmx_pkg::CH_BLUE, dmx_pkg::VALUE_W'(255 - v)};
            end
            dmx_pkg::FP_STROBE: begin
                got = 1'b1;
                upd = '{dmx_pkg::CH_STROBE, dmx_pkg::VALUE_W'(v)};
            end
            default: armed = 1'b0;
        endcase
    endfunction

    always @(posedge aclk) begin
        bit                 got;
        dmx_pkg::out_word_t upd;
        dmx_pkg::out_word_t want;
        if (!aresetn) begin
            s_valid <= 1'b0;
            m_ready <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                decode_byte(cur_row.word, got, upd);
                if (cur_row.typed) begin
                    if (cur_row.typed_hit)
                        update_q.push_back(dmx_pkg::out_word_t'{cur_row.typed_id,
                                                                cur_row.typed_val});
                end else if (got) begin
                    update_q.push_back(upd);
                end
            end
            // hold the word until it is taken
            if (!s_valid || s_ready) begin
                if (byte_q.size() != 0 && $urandom_range(0, 99) >= send_idle) begin
                    cur_row = byte_q.pop_front();
                    s_data <= cur_row.word;
                    s_valid <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
            if (m_valid && m_ready) begin
                if (update_q.size() == 0) begin
                    $error("unexpected update: channel_id %0d channel_value %0d",
                           m_data.channel_id, m_data.channel_value);
                    fail_cnt++;
                end else begin
                    want = update_q.pop_front();
                    if (m_data.channel_id !== want.channel_id) begin
                        $error("channel_id: expected %0d, got %0d",
                               want.channel_id, m_data.channel_id);
                        fail_cnt++;
                    end
                    if (m_data.channel_value !== want.channel_value) begin
                        $error("channel_value: expected %0d, got %0d",
                               want.channel_value, m_data.channel_value);
                        fail_cnt++;
                    end
                end
            end
            m_ready <= ($urandom_range(0, 99) >= recv_idle);
        end
    end

    function automatic void push_word(logic [7:0] b, logic brk);
        byte_row_t r;
        r = '0;
        r.word = '{b, brk};
        byte_q.push_back(r);
        queued++;
    endfunction

    function automatic logic [7:0] pick_byte();
        // favor a few values so colours repeat often
        case ($urandom_range(0, 5))
            0: return 8'h00;
            1: return 8'hFF;
            2: return 8'h80;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic void add_frame(int addr, bit cut);
        int len;
        push_word(8'($urandom_range(0, 255)), 1'b1);
        len = (addr <= MAX_SLOT + 1) ? addr + 7 : 530;
        if (cut)
            len = $urandom_range(0, len - 1);
        else
            len += $urandom_range(0, 2);
        for (int i = 0; i < len; i++)
            push_word(pick_byte(), 1'b0);
    endfunction

    task automatic drain();
        while (byte_q.size() != 0 || s_valid || update_q.size() != 0)
            @(posedge aclk);
        // let a word that gives no update clear the pipe
        repeat (4) @(posedge aclk);
    endtask

    task automatic set_start_address(int addr);
        drain();
        cfg_valid <= 1'b1;
        cfg_data <= dmx_pkg::CFG_W'(addr);
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        start_addr = dmx_pkg::CFG_W'(addr);
    endtask

    task automatic run_phase(int addr, int budget);
        int base;
        int kind;
        set_start_address(addr);
        base = queued;
        while (queued - base < budget) begin
            kind = $urandom_range(0, 19);
            if (kind < 2)
                push_word(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            else if (kind < 5)
                add_frame(addr, 1'b1);
            else
                add_frame(addr, 1'b0);
        end
    endtask

    initial begin
        send_idle = 32;
        recv_idle = 51;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        phase_addr[4] = $urandom_range(2, 24);
        phase_addr[8] = $urandom_range(1, 40);
        foreach (directed_rows[i])
            byte_q.push_back(directed_rows[i]);
        for (int p = 0; p < N_PHASES; p++) begin
            if (p == 3) begin
                send_idle = 51;
                recv_idle = 32;
            end
            if (p == 6) begin
                send_idle = 0;
                recv_idle = 0;
            end
            run_phase(phase_addr[p], phase_budget[p]);
        end
        drain();
        if (fail_cnt == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial begin
        #5000000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
